// ===== rtl/recursive_rw_lock_manager_macros.svh =====
// ============================================================================
// Recursive RW lock manager assertion macros
// Shared assertion wrappers; they expand to nothing in synthesis builds.
// ============================================================================
`ifndef RECURSIVE_RW_LOCK_MANAGER_MACROS_SVH
`define RECURSIVE_RW_LOCK_MANAGER_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition holds on every clock edge outside reset.
`define RRWL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rrwl assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define RRWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrwl assertion failed");

`else

`define RRWL_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define RRWL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rrwl_pkg.sv =====
// ============================================================================
// Recursive RW lock manager package
// Command and status codes, controller types and parameter defaults.
// ============================================================================
package rrwl_pkg;

    localparam int THREADS_DEF    = 16;
    localparam int DEPTH_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CMD_LOCK_READ  = 3'd0,
        CMD_LOCK_WRITE = 3'd1,
        CMD_UNLOCK     = 3'd2,
        CMD_UPGRADE    = 3'd3,
        CMD_DEGRADE    = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_BUSY    = 2'd1,
        ST_REFUSED = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ctrl_sts_t;

endpackage

// ===== rtl/rrwl_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
module rrwl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rrwl_ctrl.sv =====
// ============================================================================
// Recursive RW lock manager controller
// Sequences the table read and the commit of one request.
// ============================================================================
module rrwl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rrwl_pkg::ctrl_sts_t   sts,
    output rrwl_pkg::ctrl_cmd_t   cmd
);

    import rrwl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.commit = !sts.out_busy;
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rrwl_datapath.sv =====
// ============================================================================
// Recursive RW lock manager datapath
// Lock state, per-thread read depth table and the result register.
// ============================================================================
`include "recursive_rw_lock_manager_macros.svh"

module rrwl_datapath #(
    parameter int THREADS    = rrwl_pkg::THREADS_DEF,
    parameter int DEPTH_BITS = rrwl_pkg::DEPTH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rrwl_pkg::ctrl_cmd_t   ctrl,
    output rrwl_pkg::ctrl_sts_t   sts,
    input  logic [2:0]            command,
    input  logic [3:0]            thread,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  in_use,
    output logic                  writer_held,
    output logic [4:0]            reader_total
);

    import rrwl_pkg::*;

    localparam int IDX_W = $clog2(THREADS);
    localparam int CNT_W = $clog2(THREADS + 1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(THREADS);

    logic [2:0]            cmd_reg;
    logic [3:0]            thread_reg;
    logic                  writer_reg;
    logic                  writer_next;
    logic [3:0]            owner_reg;
    logic [3:0]            owner_next;
    logic [DEPTH_BITS-1:0] wdepth_reg;
    logic [DEPTH_BITS-1:0] wdepth_next;
    logic [CNT_W-1:0]      readers_reg;
    logic [CNT_W-1:0]      readers_next;
    logic                  vld_reg [THREADS];
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            status_reg;
    logic                  in_use_reg;
    logic                  writer_held_reg;
    logic [4:0]            reader_total_reg;

    status_t               status_next;
    logic [IDX_W-1:0]      thread_idx;
    logic                  thread_ok;
    logic                  is_owner;
    logic [DEPTH_BITS-1:0] tbl_rdata;
    logic [DEPTH_BITS-1:0] rd;
    logic [DEPTH_BITS-1:0] rd_inc;
    logic                  tbl_we;
    logic [DEPTH_BITS-1:0] tbl_wdata;

    assign thread_idx = IDX_W'(thread_reg);
    assign thread_ok  = (9'(thread_reg) < 9'(THREADS));
    assign is_owner   = writer_reg && (owner_reg == thread_reg);
    assign rd         = (thread_ok && vld_reg[thread_idx]) ? tbl_rdata : '0;
    assign rd_inc     = (rd == DEPTH_MAX) ? DEPTH_MAX : rd + 1'b1;

    rrwl_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (THREADS)
    ) u_depth_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (thread_idx),
        .wdata (tbl_wdata),
        .re    (ctrl.capture),
        .raddr (IDX_W'(thread)),
        .rdata (tbl_rdata)
    );

    always_comb
    begin
        writer_next  = writer_reg;
        owner_next   = owner_reg;
        wdepth_next  = wdepth_reg;
        readers_next = readers_reg;
        status_next  = ST_REFUSED;
        tbl_we       = 1'b0;
        tbl_wdata    = rd;
        if (thread_ok)
        begin
            unique case (cmd_reg)
                CMD_LOCK_READ:
                begin
                    if (is_owner)
                    begin
                        status_next = ST_GRANTED;
                    end
                    else if (rd != '0)
                    begin
                        tbl_we      = 1'b1;
                        tbl_wdata   = rd_inc;
                        status_next = ST_GRANTED;
                    end
                    else if (writer_reg)
                    begin
                        status_next = ST_BUSY;
                    end
                    else
                    begin
                        tbl_we      = 1'b1;
                        tbl_wdata   = DEPTH_BITS'(1);
                        status_next = ST_GRANTED;
                        if (readers_reg != CNT_MAX)
                        begin
                            readers_next = readers_reg + 1'b1;
                        end
                    end
                end
                CMD_LOCK_WRITE:
                begin
                    if (is_owner)
                    begin
                        wdepth_next = (wdepth_reg == DEPTH_MAX) ? DEPTH_MAX
                                                                : wdepth_reg + 1'b1;
                        status_next = ST_GRANTED;
                    end
                    else if (writer_reg || readers_reg != '0)
                    begin
                        status_next = ST_BUSY;
                    end
                    else
                    begin
                        writer_next = 1'b1;
                        owner_next  = thread_reg;
                        wdepth_next = DEPTH_BITS'(1);
                        status_next = ST_GRANTED;
                    end
                end
                CMD_UNLOCK:
                begin
                    status_next = ST_GRANTED;
                    if (writer_reg)
                    begin
                        if (is_owner && wdepth_reg > DEPTH_BITS'(1))
                        begin
                            wdepth_next = wdepth_reg - 1'b1;
                        end
                        else
                        begin
                            if (is_owner)
                            begin
                                wdepth_next = '0;
                                owner_next  = '0;
                            end
                            writer_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if (rd != '0)
                        begin
                            tbl_we    = 1'b1;
                            tbl_wdata = rd - 1'b1;
                        end
                        if (rd <= DEPTH_BITS'(1) && readers_reg != '0)
                        begin
                            readers_next = readers_reg - 1'b1;
                        end
                    end
                end
                CMD_UPGRADE:
                begin
                    if (is_owner)
                    begin
                        status_next = ST_GRANTED;
                    end
                    else if (writer_reg || readers_reg > CNT_W'(rd != '0))
                    begin
                        status_next = ST_BUSY;
                    end
                    else
                    begin
                        if (rd != '0)
                        begin
                            tbl_we    = 1'b1;
                            tbl_wdata = '0;
                            if (readers_reg != '0)
                            begin
                                readers_next = readers_reg - 1'b1;
                            end
                        end
                        writer_next = 1'b1;
                        owner_next  = thread_reg;
                        wdepth_next = DEPTH_BITS'(1);
                        status_next = ST_GRANTED;
                    end
                end
                CMD_DEGRADE:
                begin
                    if (writer_reg)
                    begin
                        tbl_we      = 1'b1;
                        tbl_wdata   = rd_inc;
                        writer_next = 1'b0;
                        status_next = ST_GRANTED;
                        if (rd == '0 && readers_reg != CNT_MAX)
                        begin
                            readers_next = readers_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_REFUSED;
                end
            endcase
        end
        tbl_we = tbl_we && ctrl.commit;
    end

    always_comb
    begin
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg    <= command;
            thread_reg <= thread;
        end
        if (ctrl.commit)
        begin
            status_reg       <= status_next;
            in_use_reg       <= writer_next || (readers_next != '0);
            writer_held_reg  <= writer_next;
            reader_total_reg <= 5'(readers_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writer_reg    <= 1'b0;
            owner_reg     <= '0;
            wdepth_reg    <= '0;
            readers_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < THREADS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctrl.commit)
            begin
                writer_reg  <= writer_next;
                owner_reg   <= owner_next;
                wdepth_reg  <= wdepth_next;
                readers_reg <= readers_next;
            end
            if (tbl_we)
            begin
                vld_reg[thread_idx] <= 1'b1;
            end
        end
    end

    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign in_use       = in_use_reg;
    assign writer_held  = writer_held_reg;
    assign reader_total = reader_total_reg;

    `RRWL_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, ctrl.commit, out_valid_reg)
    `RRWL_ASSERT_ALWAYS(a_readers_bounded, clk, rst_n, readers_reg <= CNT_MAX)
    `RRWL_ASSERT_ALWAYS(a_writer_has_depth, clk, rst_n, !writer_reg || wdepth_reg != '0)
    `RRWL_ASSERT_ALWAYS(a_no_capture_on_commit, clk, rst_n, !(ctrl.capture && ctrl.commit))

endmodule

// ===== rtl/recursive_rw_lock_manager.sv =====
// ============================================================================
// Recursive reader-writer lock manager
// Grants, refuses or answers busy to read and write lock requests per thread.
// ============================================================================
//  Channel   Handshake            Payload
//  request   in_valid / in_ready  command, thread
//  result    out_valid/out_ready  status, in_use, writer_held, reader_total
//
//  Each request first reads the thread's read depth from the table RAM,
//  then updates the lock state and writes the table back.
//  A new request is taken only after the previous one has been committed.
//  A result waits in the output register; a stalled result holds back only
//  the commit of the following request.
//  Reset clears the lock state and the table valid bits at once.
// ============================================================================
module recursive_rw_lock_manager #(
    parameter int THREADS    = rrwl_pkg::THREADS_DEF,
    parameter int DEPTH_BITS = rrwl_pkg::DEPTH_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [3:0] thread,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic       in_use,
    output logic       writer_held,
    output logic [4:0] reader_total
);

    import rrwl_pkg::*;

    ctrl_cmd_t ctrl;
    ctrl_sts_t sts;

    rrwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (ctrl)
    );

    rrwl_datapath #(
        .THREADS    (THREADS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sts          (sts),
        .command      (command),
        .thread       (thread),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .in_use       (in_use),
        .writer_held  (writer_held),
        .reader_total (reader_total)
    );

endmodule
